### rtl/core/wnafr_pkg.sv
// Shared constants and types for the width-w NAF scalar recoder.
`timescale 1ns / 1ps
package wnafr_pkg;

  // Fixed field widths of the item ports.
  localparam int BYTE_W = 8;
  localparam int DIGIT_W = 5;
  localparam int POS_OUT_W = 9;

  // Defaults for the top-level parameters.
  localparam int SCALAR_BYTES_DEF = 32;
  localparam int WINDOW_DEF = 5;

  // Depth of the queue between the front and the back.
  localparam int QUEUE_DEPTH = 2;

  // One classified scalar byte on its way to the recoding engine.
  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              last;
  } byte_entry_t;

endpackage

### rtl/core/wnafr_front.sv
// Front end: accepts scalar bytes and tags the final byte of each scalar.
`timescale 1ns / 1ps
module wnafr_front #(
  parameter int SCALAR_BYTES = wnafr_pkg::SCALAR_BYTES_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  output logic                        full,
  input  logic [wnafr_pkg::BYTE_W-1:0] scalar_byte,
  input  logic                        q_full,
  output logic                        q_wr,
  output wnafr_pkg::byte_entry_t      q_entry
);

  localparam int IDX_W = $clog2(SCALAR_BYTES);

  logic [IDX_W-1:0] byte_index;
  logic             is_last;

  // The input side is full whenever the queue is.
  assign full    = q_full;
  assign q_wr    = push && !q_full;
  assign is_last = (byte_index == IDX_W'(SCALAR_BYTES - 1));

  always_comb begin
    q_entry.data = scalar_byte;
    q_entry.last = is_last;
  end

  // Count bytes within the scalar, wrapping after the final one.
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_index <= '0;
    end else if (q_wr) begin
      if (is_last) begin
        byte_index <= '0;
      end else begin
        byte_index <= byte_index + IDX_W'(1);
      end
    end
  end

endmodule

### rtl/core/wnafr_queue.sv
// Short queue of classified bytes between the front and the back.
`timescale 1ns / 1ps
module wnafr_queue (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   wr,
  input  wnafr_pkg::byte_entry_t wr_entry,
  output logic                   q_full,
  input  logic                   rd,
  output logic                   q_valid,
  output wnafr_pkg::byte_entry_t rd_entry
);

  localparam int DEPTH = wnafr_pkg::QUEUE_DEPTH;
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  wnafr_pkg::byte_entry_t mem [DEPTH];
  logic [AW-1:0] wptr;
  logic [AW-1:0] rptr;
  logic [CW-1:0] count;
  logic          do_wr;
  logic          do_rd;

  assign q_full   = (count == CW'(DEPTH));
  assign q_valid  = (count != '0);
  assign do_wr    = wr && !q_full;
  assign do_rd    = rd && q_valid;
  assign rd_entry = mem[rptr];

  // Storage for waiting items.
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wptr] <= wr_entry;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_wr) begin
        wptr <= (wptr == AW'(DEPTH - 1)) ? '0 : wptr + AW'(1);
      end
      if (do_rd) begin
        rptr <= (rptr == AW'(DEPTH - 1)) ? '0 : rptr + AW'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + CW'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

### rtl/core/wnafr_back.sv
// Back end: recodes bits into wNAF digits, one per unstalled cycle, into an output register.
`timescale 1ns / 1ps
module wnafr_back #(
  parameter int SCALAR_BYTES = wnafr_pkg::SCALAR_BYTES_DEF,
  parameter int WINDOW       = wnafr_pkg::WINDOW_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            q_valid,
  input  wnafr_pkg::byte_entry_t          q_entry,
  output logic                            q_rd,
  input  logic                            pop,
  output logic                            empty,
  output logic [wnafr_pkg::DIGIT_W-1:0]   digit,
  output logic [wnafr_pkg::POS_OUT_W-1:0] position,
  output logic                            digit_last,
  output logic [wnafr_pkg::POS_OUT_W-1:0] top_plus_one
);

  localparam int BW      = wnafr_pkg::BYTE_W;
  localparam int PW      = WINDOW + BW - 1;
  localparam int CNT_W   = $clog2(PW + 1);
  localparam int SKIP_W  = $clog2(WINDOW);
  localparam int DW      = WINDOW + 1;
  localparam int TOP_POS = 8 * SCALAR_BYTES;
  localparam int POS_W   = $clog2(TOP_POS + 2);
  localparam int OW      = wnafr_pkg::POS_OUT_W;
  localparam int GW      = wnafr_pkg::DIGIT_W;

  // Recoding state.
  logic [PW-1:0]     pending_bits, pending_bits_next;
  logic [CNT_W-1:0]  pending_count, pending_count_next;
  logic              carry_in, carry_in_next;
  logic [SKIP_W-1:0] skip_count, skip_count_next;
  logic [POS_W-1:0]  digit_position, digit_position_next;
  logic [POS_W-1:0]  top_seen, top_seen_next;
  logic              active, active_next;
  logic              flush, flush_next;

  // Output register.
  logic              out_valid;
  logic [GW-1:0]     out_digit;
  logic [OW-1:0]     out_pos;
  logic              out_last;
  logic [OW-1:0]     out_top;

  // Per-digit working values.
  logic              emit;
  logic              done_now;
  logic              is_last;
  logic [1:0]        eff;
  logic [DW-1:0]     win_val;
  logic signed [DW-1:0] d;
  logic [DW+GW-1:0]  d_ext;
  logic              formed;
  logic [POS_W-1:0]  top_after;
  logic [POS_W+OW-1:0] pos_ext;
  logic [POS_W+OW-1:0] top_ext;

  assign empty        = !out_valid;
  assign digit        = out_digit;
  assign position     = out_pos;
  assign digit_last   = out_last;
  assign top_plus_one = out_top;

  // While active, a digit is produced whenever the output register is free or being drained.
  assign emit    = active && (!out_valid || pop);
  assign is_last = flush && (digit_position == POS_W'(TOP_POS));
  assign eff     = {1'b0, pending_bits[0]} + {1'b0, carry_in};
  assign win_val = {1'b0, pending_bits[WINDOW-1:0]} + DW'(carry_in);
  assign formed  = (skip_count == '0) && eff[0];
  assign top_after = formed ? digit_position + POS_W'(1) : top_seen;
  assign d_ext   = {{GW{d[DW-1]}}, d};
  assign pos_ext = {{OW{1'b0}}, digit_position};
  assign top_ext = {{OW{1'b0}}, top_after};

  // Digit value for the current position.
  always_comb begin
    d = '0;
    if (formed) begin
      if (win_val > DW'(1 << (WINDOW - 1))) begin
        d = signed'(win_val - DW'(1 << WINDOW));
      end else begin
        d = signed'(win_val);
      end
    end
  end

  // State after this cycle's digit, then the load of the next byte.
  always_comb begin
    pending_bits_next   = pending_bits;
    pending_count_next  = pending_count;
    carry_in_next       = carry_in;
    skip_count_next     = skip_count;
    digit_position_next = digit_position;
    top_seen_next       = top_seen;
    active_next         = active;
    flush_next          = flush;
    done_now            = 1'b0;
    q_rd                = 1'b0;

    if (emit) begin
      if (skip_count != '0) begin
        skip_count_next = skip_count - SKIP_W'(1);
      end else if (!eff[0]) begin
        carry_in_next = eff[1];
      end else begin
        carry_in_next   = (win_val > DW'(1 << (WINDOW - 1)));
        skip_count_next = SKIP_W'(WINDOW - 1);
      end
      top_seen_next       = top_after;
      pending_bits_next   = pending_bits >> 1;
      pending_count_next  = (pending_count != '0) ? pending_count - CNT_W'(1) : '0;
      digit_position_next = digit_position + POS_W'(1);

      if (flush) begin
        done_now = is_last;
      end else begin
        done_now = (pending_count_next < CNT_W'(WINDOW));
      end

      if (done_now) begin
        active_next = 1'b0;
        // The end of a scalar returns everything to its reset value.
        if (flush) begin
          pending_bits_next   = '0;
          pending_count_next  = '0;
          carry_in_next       = 1'b0;
          skip_count_next     = '0;
          digit_position_next = '0;
          top_seen_next       = '0;
          flush_next          = 1'b0;
        end
      end
    end

    // Append the next byte above the bits still pending.
    if (q_valid && (!active || done_now)) begin
      q_rd               = 1'b1;
      pending_bits_next  = pending_bits_next | (PW'(q_entry.data) << pending_count_next);
      pending_count_next = pending_count_next + CNT_W'(BW);
      active_next        = 1'b1;
      flush_next         = q_entry.last;
    end
  end

  // Engine registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      pending_bits   <= '0;
      pending_count  <= '0;
      carry_in       <= 1'b0;
      skip_count     <= '0;
      digit_position <= '0;
      top_seen       <= '0;
      active         <= 1'b0;
      flush          <= 1'b0;
    end else begin
      pending_bits   <= pending_bits_next;
      pending_count  <= pending_count_next;
      carry_in       <= carry_in_next;
      skip_count     <= skip_count_next;
      digit_position <= digit_position_next;
      top_seen       <= top_seen_next;
      active         <= active_next;
      flush          <= flush_next;
    end
  end

  // Output valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  // Output payload.
  always_ff @(posedge clk) begin
    if (emit) begin
      out_digit <= d_ext[GW-1:0];
      out_pos   <= pos_ext[OW-1:0];
      out_last  <= is_last;
      out_top   <= is_last ? top_ext[OW-1:0] : '0;
    end
  end

endmodule

### rtl/core/wnaf_scalar_recoder_top.sv
// Top level of the width-w NAF scalar recoder.
//
// Input channel: one scalar byte per item, least significant byte first,
// SCALAR_BYTES items per scalar. An item is taken when push is high and
// full is low. The front tags the final byte of each scalar and parks items
// in a two-entry queue.
// Result channel: one signed digit per item with its bit position. The oldest
// digit is shown while empty is low and is taken when pop is high.
// The last digit of a scalar (position 8*SCALAR_BYTES) raises digit_last and
// carries the highest nonzero position plus one.
// Path: a byte is written into the queue, loaded into the engine registers
// and recoded into the output register, which shows its first digit. The
// engine produces one digit per cycle while the output register is free or
// being drained; the first byte of a scalar yields 9-WINDOW digits, a middle
// byte 8 and the final byte WINDOW+8, and the single engine sets the rate.
// When the receiver stalls, the engine holds and the queue fills; full rises
// once two bytes wait. Reset (synchronous, active high) empties the queue
// and the output register and starts a new scalar.
`timescale 1ns / 1ps
module wnaf_scalar_recoder_top #(
  parameter int SCALAR_BYTES = wnafr_pkg::SCALAR_BYTES_DEF,
  parameter int WINDOW       = wnafr_pkg::WINDOW_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            push,
  output logic                            full,
  input  logic [wnafr_pkg::BYTE_W-1:0]    scalar_byte,
  output logic                            empty,
  input  logic                            pop,
  output logic [wnafr_pkg::DIGIT_W-1:0]   digit,
  output logic [wnafr_pkg::POS_OUT_W-1:0] position,
  output logic                            digit_last,
  output logic [wnafr_pkg::POS_OUT_W-1:0] top_plus_one
);

  logic                   q_full;
  logic                   q_wr;
  logic                   q_rd;
  logic                   q_valid;
  wnafr_pkg::byte_entry_t wr_entry;
  wnafr_pkg::byte_entry_t rd_entry;

  // Byte intake and end-of-scalar tagging.
  wnafr_front #(
    .SCALAR_BYTES(SCALAR_BYTES)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .scalar_byte(scalar_byte),
    .q_full     (q_full),
    .q_wr       (q_wr),
    .q_entry    (wr_entry)
  );

  // Decoupling queue.
  wnafr_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (q_wr),
    .wr_entry(wr_entry),
    .q_full  (q_full),
    .rd      (q_rd),
    .q_valid (q_valid),
    .rd_entry(rd_entry)
  );

  // Recoding engine and result register.
  wnafr_back #(
    .SCALAR_BYTES(SCALAR_BYTES),
    .WINDOW      (WINDOW)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .q_entry     (rd_entry),
    .q_rd        (q_rd),
    .pop         (pop),
    .empty       (empty),
    .digit       (digit),
    .position    (position),
    .digit_last  (digit_last),
    .top_plus_one(top_plus_one)
  );

endmodule
